>>> rtl/cpu_bus_decode_with_oam_dma_unit_assert.svh
// Assertion macros for the CPU bus decode block with sprite DMA.
`ifndef CPU_BUS_DECODE_WITH_OAM_DMA_UNIT_ASSERT_SVH
`define CPU_BUS_DECODE_WITH_OAM_DMA_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CBD_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbd: same-cycle check failed");
`define CBD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbd: next-cycle check failed");
`else
`define CBD_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define CBD_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/cbd_pkg.sv
// Shared types and constants of the CPU bus decode block.
package cbd_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  localparam logic [15:0] ADDR_RAM_END  = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_END  = 16'h3FFF;
  localparam logic [15:0] ADDR_OAM_DMA  = 16'h4014;
  localparam logic [15:0] ADDR_PAD_ONE  = 16'h4016;
  localparam logic [15:0] ADDR_PAD_TWO  = 16'h4017;
  localparam logic [15:0] RAM_MIRROR_MASK = 16'h1FFF;
  localparam int unsigned MIRROR_BITS   = 13;
  localparam logic [2:0]  PHASE_LAST    = 3'd5;
  localparam logic [2:0]  PHASE_DMA_EVEN = 3'd0;
  localparam logic [2:0]  PHASE_DMA_ODD  = 3'd3;
  localparam logic [7:0]  OFFSET_LAST   = 8'hFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        read_only;
    logic        cart_hit;
    logic [7:0]  cart_rdata;
    logic [7:0]  ppu_rdata;
    logic [7:0]  pad_one;
    logic [7:0]  pad_two;
    logic        ppu_nmi;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        ppu_access;
    logic [2:0]  ppu_reg;
    logic        ppu_write;
    logic        cpu_step;
    logic        dma_reading;
    logic [15:0] dma_read_addr;
    logic        oam_write;
    logic [7:0]  oam_addr;
    logic [7:0]  oam_data;
    logic        cpu_nmi;
  } out_beat_t;

  // Result of the decode stage; RAM data and the DMA byte join it once it is registered.
  typedef struct packed {
    logic [7:0]  rdata;
    logic        use_ram;
    logic        ppu_access;
    logic [2:0]  ppu_reg;
    logic        ppu_write;
    logic        cpu_step;
    logic        dma_reading;
    logic [15:0] dma_read_addr;
    logic        oam_write;
    logic [7:0]  oam_addr;
    logic        cpu_nmi;
  } stage_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [7:0] wdata;
  } ram_cmd_t;

endpackage

>>> rtl/cbd_if.sv
// Valid/ready channel interfaces for bus requests and results.
interface cbd_in_if;
  logic              valid;
  logic              ready;
  cbd_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbd_out_if;
  logic               valid;
  logic               ready;
  cbd_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cbd_ram.sv
// Work RAM: single-port synchronous memory with registered read data.
module cbd_ram #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/cbd_ctrl.sv
// Address decode, controller latches, tick phase and sprite DMA sequencing.
module cbd_ctrl #(
  parameter int unsigned RAM_BYTES = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  cbd_pkg::in_beat_t            beat_i,
  output cbd_pkg::stage_t              stage_o,
  output cbd_pkg::ram_cmd_t            ram_cmd_o,
  output logic [$clog2(RAM_BYTES)-1:0] ram_addr_o
);
  import cbd_pkg::*;

  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);
  localparam int unsigned RW = MIRROR_BITS + 5;
  localparam int unsigned QUOT_STEPS = MIRROR_BITS - RAM_AW + 1;
  localparam logic [RW-1:0] DEPTH_W = RW'(RAM_BYTES);

  // Mirror the 8 KB window onto the RAM; the quotient is a few bits wide,
  // so a short restoring subtract chain suffices.
  function automatic logic [RAM_AW-1:0] ram_index(input logic [15:0] a);
    logic [RW-1:0] r;
    r = RW'(a & RAM_MIRROR_MASK);
    for (int s = QUOT_STEPS - 1; s >= 0; s--) begin
      if (r >= (DEPTH_W << s)) begin
        r = r - (DEPTH_W << s);
      end
    end
    return r[RAM_AW-1:0];
  endfunction

  logic [1:0][7:0] pad_q, pad_d;
  logic [2:0]      phase_q, phase_d;
  logic [7:0]      page_q, page_d;
  logic [7:0]      offset_q, offset_d;
  logic            waiting_q, waiting_d;
  logic            active_q, active_d;

  req_e        req;
  logic        bus_rd;
  logic [15:0] baddr;
  logic [15:0] fetch_addr;
  logic        dma_slot;
  logic        ram_hit;
  logic        pad_sel;
  stage_t      st;
  ram_cmd_t    cmd;

  always_comb begin
    req      = req_e'(beat_i.req_type);
    fetch_addr = {page_q, offset_q};
    dma_slot = (phase_q == PHASE_DMA_EVEN) || (phase_q == PHASE_DMA_ODD);
    st       = '0;
    cmd      = '0;
    bus_rd   = 1'b0;
    baddr    = beat_i.addr;
    pad_d    = pad_q;
    phase_d  = phase_q;
    page_d   = page_q;
    offset_d = offset_q;
    waiting_d = waiting_q;
    active_d = active_q;
    ram_hit  = !beat_i.cart_hit && (beat_i.addr <= ADDR_RAM_END);

    case (req)
      REQ_READ: begin
        bus_rd = 1'b1;
      end
      REQ_WRITE: begin
        if (beat_i.cart_hit) begin
          // The cartridge takes the write.
        end else if (beat_i.addr <= ADDR_RAM_END) begin
          cmd.wr    = 1'b1;
          cmd.wdata = beat_i.wdata;
        end else if (beat_i.addr <= ADDR_PPU_END) begin
          st.ppu_access = 1'b1;
          st.ppu_reg    = beat_i.addr[2:0];
          st.ppu_write  = 1'b1;
        end else if (beat_i.addr == ADDR_OAM_DMA) begin
          page_d   = beat_i.wdata;
          offset_d = '0;
          active_d = 1'b1;
        end else if (beat_i.addr == ADDR_PAD_ONE) begin
          pad_d[0] = beat_i.pad_one;
        end else if (beat_i.addr == ADDR_PAD_TWO) begin
          pad_d[1] = beat_i.pad_two;
        end
      end
      REQ_TICK: begin
        st.cpu_nmi = beat_i.ppu_nmi;
        phase_d = (phase_q >= PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
        if (dma_slot) begin
          if (!active_q) begin
            st.cpu_step = 1'b1;
          end else if (waiting_q) begin
            if (phase_q[0]) begin
              waiting_d = 1'b0;
            end
          end else if (!phase_q[0]) begin
            bus_rd           = 1'b1;
            baddr            = fetch_addr;
            ram_hit          = !beat_i.cart_hit && (fetch_addr <= ADDR_RAM_END);
            st.dma_reading   = 1'b1;
            st.dma_read_addr = fetch_addr;
          end else begin
            st.oam_write = 1'b1;
            st.oam_addr  = offset_q;
            offset_d     = offset_q + 8'd1;
            if (offset_q == OFFSET_LAST) begin
              active_d  = 1'b0;
              waiting_d = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    pad_sel = baddr[0];
    if (bus_rd) begin
      if (beat_i.cart_hit) begin
        st.rdata = beat_i.cart_rdata;
      end else if (baddr <= ADDR_RAM_END) begin
        st.use_ram = 1'b1;
        cmd.rd     = 1'b1;
      end else if (baddr <= ADDR_PPU_END) begin
        st.ppu_access = 1'b1;
        st.ppu_reg    = baddr[2:0];
        st.rdata      = beat_i.ppu_rdata;
      end else if ((baddr == ADDR_PAD_ONE) || (baddr == ADDR_PAD_TWO)) begin
        st.rdata       = {7'd0, pad_q[pad_sel][7]};
        pad_d[pad_sel] = {pad_q[pad_sel][6:0], 1'b0};
      end
    end
  end

  assign stage_o   = st;
  assign ram_cmd_o = '{rd: cmd.rd && ram_hit && accept_i,
                       wr: cmd.wr && ram_hit && accept_i,
                       wdata: cmd.wdata};
  assign ram_addr_o = ram_index(baddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q     <= '0;
      phase_q   <= '0;
      page_q    <= '0;
      offset_q  <= '0;
      waiting_q <= 1'b1;
      active_q  <= 1'b0;
    end else if (accept_i) begin
      pad_q     <= pad_d;
      phase_q   <= phase_d;
      page_q    <= page_d;
      offset_q  <= offset_d;
      waiting_q <= waiting_d;
      active_q  <= active_d;
    end
  end
endmodule

>>> rtl/cpu_bus_decode_with_oam_dma_unit.sv
// Top level: CPU bus decode with work RAM, controller latches and sprite DMA.
//
//   Port    Dir  Beat contents
//   req_i   in   CPU read, CPU write or system tick with cartridge/PPU/pad inputs
//   rsp_o   out  read data, PPU access, CPU step, NMI, DMA read and sprite write fields
//
// One beat is accepted per cycle unless the output stalls; results pass through
// the first stage and the output register. Decode and all small state update at
// acceptance; the RAM read is merged in stage two, which also latches the DMA byte.
// Reset clears the latches, the tick phase and the DMA state; the RAM is not cleared.
// A stalled result holds the second stage, so two beats can be buffered before
// req_i.ready drops.
`include "cpu_bus_decode_with_oam_dma_unit_assert.svh"

module cpu_bus_decode_with_oam_dma_unit #(
  parameter int unsigned RAM_BYTES = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cbd_in_if.sink           req_i,
  cbd_out_if.source        rsp_o
);
  import cbd_pkg::*;

  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

  logic              accept;
  logic              s1_adv;
  logic              s1_valid_q;
  stage_t            s1_q;
  stage_t            stage;
  ram_cmd_t          ram_cmd;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_rdata;
  logic [7:0]        dma_byte_q;
  logic              out_valid_q;
  out_beat_t         out_q;
  out_beat_t         final_beat;

  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  cbd_ctrl #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .beat_i     (req_i.data),
    .stage_o    (stage),
    .ram_cmd_o  (ram_cmd),
    .ram_addr_o (ram_addr)
  );

  cbd_ram #(
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .rd_en_i (ram_cmd.rd),
    .wr_en_i (ram_cmd.wr),
    .addr_i  (ram_addr),
    .wdata_i (ram_cmd.wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    final_beat.rdata         = s1_q.use_ram ? ram_rdata : s1_q.rdata;
    final_beat.ppu_access    = s1_q.ppu_access;
    final_beat.ppu_reg       = s1_q.ppu_reg;
    final_beat.ppu_write     = s1_q.ppu_write;
    final_beat.cpu_step      = s1_q.cpu_step;
    final_beat.dma_reading   = s1_q.dma_reading;
    final_beat.dma_read_addr = s1_q.dma_read_addr;
    final_beat.oam_write     = s1_q.oam_write;
    final_beat.oam_addr      = s1_q.oam_addr;
    final_beat.oam_data      = s1_q.oam_write ? dma_byte_q : 8'd0;
    final_beat.cpu_nmi       = s1_q.cpu_nmi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dma_byte_q  <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      // The sprite write comes at least three ticks after its read, so the
      // byte is always latched before it is needed.
      if (s1_adv && s1_valid_q && s1_q.dma_reading) begin
        dma_byte_q <= final_beat.rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= stage;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= final_beat;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  `CBD_ASSERT_IMPL(a_full_blocks_input, clk_i, rst_ni, s1_valid_q && out_valid_q && !rsp_o.ready, !req_i.ready)
  `CBD_ASSERT_NEXT(a_ram_data_held, clk_i, rst_ni, s1_valid_q && !s1_adv, $stable(ram_rdata))
  `CBD_ASSERT_IMPL(a_oam_byte_matches, clk_i, rst_ni, out_valid_q && out_q.oam_write, out_q.oam_data == dma_byte_q)
endmodule

>>> dv/cpu_bus_decode_with_oam_dma_unit_tb.sv
// Self-checking testbench for the CPU bus decode block with sprite DMA.
`timescale 1ns / 100ps

module cpu_bus_decode_with_oam_dma_unit_tb;
  import cbd_pkg::*;

  localparam int unsigned RAM_BYTES = 2048;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  class bus_decode_scoreboard;
    logic [7:0]  ram [RAM_BYTES];
    bit          ram_known [RAM_BYTES];
    int unsigned written_q[$];
    logic [7:0]  pad_latch [2];
    logic [2:0]  phase;
    logic [7:0]  xfer_page;
    logic [7:0]  dma_offset;
    logic [7:0]  dma_byte;
    logic        dma_waiting;
    logic        dma_active;
    out_beat_t   expected_q[$];
    int unsigned errors;

    function new();
      pad_latch[0] = '0;
      pad_latch[1] = '0;
      phase = '0;
      xfer_page = '0;
      dma_offset = '0;
      dma_byte = '0;
      dma_waiting = 1'b1;
      dma_active = 1'b0;
      errors = 0;
    endfunction

    function int unsigned ram_slot(logic [15:0] a);
      return (a & RAM_MIRROR_MASK) % RAM_BYTES;
    endfunction

    // The DMA fetches only on the even DMA phase once its wait for an odd phase is over.
    function bit dma_reads_now(output logic [15:0] a);
      a = {xfer_page, dma_offset};
      return dma_active && !dma_waiting && phase == PHASE_DMA_EVEN;
    endfunction

    function logic [7:0] bus_fetch(logic [15:0] a, in_beat_t b, inout out_beat_t e);
      logic [7:0] d;
      d = '0;
      if (b.cart_hit) begin
        d = b.cart_rdata;
      end else if (a <= ADDR_RAM_END) begin
        d = ram[ram_slot(a)];
      end else if (a <= ADDR_PPU_END) begin
        e.ppu_access = 1'b1;
        e.ppu_reg = a[2:0];
        d = b.ppu_rdata;
      end else if (a == ADDR_PAD_ONE || a == ADDR_PAD_TWO) begin
        d = {7'd0, pad_latch[a[0]][7]};
        pad_latch[a[0]] = pad_latch[a[0]] << 1;
      end
      return d;
    endfunction

    // True when the beat would read a RAM byte that was never written.
    function bit reads_blank_ram(in_beat_t b);
      logic [15:0] a;
      a = b.addr;
      if (b.cart_hit || b.req_type == REQ_WRITE || b.req_type == REQ_UNUSED) return 1'b0;
      if (b.req_type == REQ_TICK && !dma_reads_now(a)) return 1'b0;
      return a <= ADDR_RAM_END && !ram_known[ram_slot(a)];
    endfunction

    function void accept_request(in_beat_t b);
      out_beat_t   e;
      logic [15:0] a;
      logic [7:0]  d;
      int unsigned slot;
      e = '0;
      case (b.req_type)
        REQ_READ: begin
          d = bus_fetch(b.addr, b, e);
          e.rdata = d;
        end
        REQ_WRITE: begin
          if (!b.cart_hit) begin
            if (b.addr <= ADDR_RAM_END) begin
              slot = ram_slot(b.addr);
              ram[slot] = b.wdata;
              if (!ram_known[slot]) begin
                ram_known[slot] = 1'b1;
                written_q.push_back(slot);
              end
            end else if (b.addr <= ADDR_PPU_END) begin
              e.ppu_access = 1'b1;
              e.ppu_reg = b.addr[2:0];
              e.ppu_write = 1'b1;
            end else if (b.addr == ADDR_OAM_DMA) begin
              // A restart keeps the wait flag as it stands.
              xfer_page = b.wdata;
              dma_offset = '0;
              dma_active = 1'b1;
            end else if (b.addr == ADDR_PAD_ONE) begin
              pad_latch[0] = b.pad_one;
            end else if (b.addr == ADDR_PAD_TWO) begin
              pad_latch[1] = b.pad_two;
            end
          end
        end
        REQ_TICK: begin
          if (phase == PHASE_DMA_EVEN || phase == PHASE_DMA_ODD) begin
            if (!dma_active) begin
              e.cpu_step = 1'b1;
            end else if (dma_waiting) begin
              if (phase == PHASE_DMA_ODD) dma_waiting = 1'b0;
            end else if (dma_reads_now(a)) begin
              d = bus_fetch(a, b, e);
              dma_byte = d;
              e.rdata = d;
              e.dma_reading = 1'b1;
              e.dma_read_addr = a;
            end else begin
              e.oam_write = 1'b1;
              e.oam_addr = dma_offset;
              e.oam_data = dma_byte;
              dma_offset = dma_offset + 8'd1;
              if (dma_offset == 8'd0) begin
                dma_active = 1'b0;
                dma_waiting = 1'b1;
              end
            end
          end
          e.cpu_nmi = b.ppu_nmi;
          phase = (phase == PHASE_LAST) ? 3'd0 : phase + 3'd1;
        end
        default: ;
      endcase
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("rdata", 16'(want.rdata), 16'(got.rdata));
      compare_field("ppu_access", 16'(want.ppu_access), 16'(got.ppu_access));
      compare_field("ppu_reg", 16'(want.ppu_reg), 16'(got.ppu_reg));
      compare_field("ppu_write", 16'(want.ppu_write), 16'(got.ppu_write));
      compare_field("cpu_step", 16'(want.cpu_step), 16'(got.cpu_step));
      compare_field("dma_reading", 16'(want.dma_reading), 16'(got.dma_reading));
      compare_field("dma_read_addr", want.dma_read_addr, got.dma_read_addr);
      compare_field("oam_write", 16'(want.oam_write), 16'(got.oam_write));
      compare_field("oam_addr", 16'(want.oam_addr), 16'(got.oam_addr));
      compare_field("oam_data", 16'(want.oam_data), 16'(got.oam_data));
      compare_field("cpu_nmi", 16'(want.cpu_nmi), 16'(got.cpu_nmi));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned quiet_cycles = 0;

  cbd_in_if  req_if ();
  cbd_out_if rsp_if ();

  bus_decode_scoreboard sb = new();

  cpu_bus_decode_with_oam_dma_unit #(
    .RAM_BYTES (RAM_BYTES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic in_beat_t random_request(int unsigned tick_pct, bit dma_start_ok);
    in_beat_t    b;
    int unsigned pick;
    b.addr = 16'($urandom);
    b.wdata = 8'($urandom);
    b.read_only = 1'($urandom);
    b.cart_rdata = 8'($urandom);
    b.ppu_rdata = 8'($urandom);
    b.pad_one = 8'($urandom);
    b.pad_two = 8'($urandom);
    b.ppu_nmi = 1'($urandom);
    b.cart_hit = ($urandom_range(99) < 10);
    pick = $urandom_range(99);
    if (pick < tick_pct) b.req_type = REQ_TICK;
    else if (pick >= 97) b.req_type = REQ_UNUSED;
    else b.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // Reads lean toward bytes already written, reached through any mirror.
      if (b.req_type == REQ_READ && sb.written_q.size() > 0 && $urandom_range(99) < 70)
        b.addr = 16'(sb.written_q[$urandom_range(sb.written_q.size() - 1)]
                 + RAM_BYTES * $urandom_range(8192 / RAM_BYTES - 1));
      else
        b.addr = 16'($urandom_range(ADDR_RAM_END));
    end else if (pick < 60) begin
      b.addr = 16'($urandom_range(ADDR_PPU_END, ADDR_RAM_END + 16'd1));
    end else if (pick < 75) begin
      b.addr = $urandom_range(1) ? ADDR_PAD_TWO : ADDR_PAD_ONE;
    end else if (pick < 80) begin
      b.addr = ADDR_OAM_DMA;
    end
    if (!dma_start_ok && b.addr == ADDR_OAM_DMA) b.addr = ADDR_OAM_DMA + 16'd1;
    return b;
  endfunction

  function automatic in_beat_t directed_beat(logic [1:0] kind, logic [15:0] a, logic [7:0] d);
    in_beat_t b;
    b = random_request(0, 1'b1);
    b.req_type = kind;
    b.addr = a;
    b.wdata = d;
    b.cart_hit = 1'b0;
    return b;
  endfunction

  task automatic push_request(in_beat_t b);
    if (sb.reads_blank_ram(b)) b.cart_hit = 1'b1;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= b;
    do @(posedge clk_i); while (!req_if.ready);
    sb.accept_request(b);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_beat_t b;
    in_beat_t plan[$];
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    src_idle_pct = 31;
    sink_idle_pct = 69;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // RAM extremes and mirrors.
    plan.push_back(directed_beat(REQ_WRITE, 16'h0000, 8'hFF));
    plan.push_back(directed_beat(REQ_WRITE, ADDR_RAM_END, 8'h00));
    plan.push_back(directed_beat(REQ_READ, 16'h0800, 8'h00));
    // PPU register window, both ends.
    plan.push_back(directed_beat(REQ_WRITE, ADDR_RAM_END + 16'd1, 8'h5A));
    b = directed_beat(REQ_READ, ADDR_PPU_END, 8'h00);
    b.read_only = 1'b1;
    plan.push_back(b);
    // Controller latches: load, then shift out, including a read flagged read-only that still shifts.
    b = directed_beat(REQ_WRITE, ADDR_PAD_ONE, 8'h00);
    b.pad_one = 8'hA5;
    plan.push_back(b);
    plan.push_back(directed_beat(REQ_READ, ADDR_PAD_ONE, 8'h00));
    b = directed_beat(REQ_READ, ADDR_PAD_ONE, 8'h00);
    b.read_only = 1'b1;
    plan.push_back(b);
    b = directed_beat(REQ_WRITE, ADDR_PAD_TWO, 8'h00);
    b.pad_two = 8'hFF;
    plan.push_back(b);
    plan.push_back(directed_beat(REQ_READ, ADDR_PAD_TWO, 8'h00));
    // Cartridge claims win over RAM and unmapped space; then plain unmapped and unused beats.
    b = directed_beat(REQ_WRITE, 16'h0001, 8'h77);
    b.cart_hit = 1'b1;
    plan.push_back(b);
    b = directed_beat(REQ_READ, 16'hFFFF, 8'h00);
    b.cart_hit = 1'b1;
    plan.push_back(b);
    plan.push_back(directed_beat(REQ_READ, 16'h8000, 8'h00));
    plan.push_back(directed_beat(REQ_UNUSED, 16'h0000, 8'h00));
    // Sprite DMA from a RAM page, then a restart mid-transfer.
    plan.push_back(directed_beat(REQ_WRITE, 16'h0200, 8'h11));
    plan.push_back(directed_beat(REQ_WRITE, 16'h0201, 8'h22));
    plan.push_back(directed_beat(REQ_WRITE, ADDR_OAM_DMA, 8'h02));
    repeat (8) plan.push_back(directed_beat(REQ_TICK, 16'h0000, 8'h00));
    plan.push_back(directed_beat(REQ_WRITE, ADDR_OAM_DMA, 8'h02));
    foreach (plan[i]) push_request(plan[i]);

    repeat (60) push_request(random_request(45, 1'b1));
    src_idle_pct = 69;
    sink_idle_pct = 31;
    repeat (60) push_request(random_request(45, 1'b1));

    // Full-speed phase: one whole 256-byte transfer with no restart.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    b = random_request(0, 1'b1);
    b.req_type = REQ_WRITE;
    b.addr = ADDR_OAM_DMA;
    b.cart_hit = 1'b0;
    push_request(b);
    while (sb.dma_active) push_request(random_request(90, 1'b0));
    repeat (30) push_request(random_request(45, 1'b1));
    req_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
